// ===== rtl/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared widths, constants and tables for the roll and pitch tilt core.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ROLL_W = 16;
  localparam int PITCH_W = 15;
  localparam int ROLL_LIMIT = 23040;
  localparam int PITCH_LIMIT = 11520;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int TABLE_SIZE = 24;

  localparam int FRAC_W = 24;
  localparam int DATA_W = 44;
  localparam int ANG_W = 35;

  localparam int SQ_W = 32;
  localparam int ROOT_W = 32;
  localparam int REM_W = ROOT_W + 4;
  localparam int ROOT_STAGES = ROOT_W / 2;
  localparam int ROOT_SHIFT = 8;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;

  localparam logic [29:0] ATAN_TABLE [TABLE_SIZE] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687, 30'd33543516, 30'd16775851, 30'd8388437,
    30'd4194283, 30'd2097149, 30'd1048576, 30'd524288,
    30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048,
    30'd1024, 30'd512, 30'd256, 30'd128
  };

  localparam logic [15:0] DEG_NUM = 16'd36672;
  localparam int DEG_SHIFT = 30;
  localparam logic [31:0] DEG_HALF = 32'd2684354560;
  localparam logic [19:0] RECIP5 = 20'd838861;
  localparam int RECIP5_SHIFT = 22;

endpackage

// ===== rtl/rpa_if.sv =====
// ----------------------------------------------------------------------------
// rpa_if
// Valid/ready channels for acceleration samples and tilt results.
// ----------------------------------------------------------------------------
interface rpa_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

interface rpa_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// ===== rtl/rpa_isqrt.sv =====
// ----------------------------------------------------------------------------
// rpa_isqrt
// Pipelined integer square root of a radicand scaled by 2^32, two result
// bits per stage, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module rpa_isqrt #(
  parameter int SIDE_W = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rpa_pkg::SQ_W-1:0]    radicand,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [rpa_pkg::ROOT_W-1:0]  root,
  output logic [SIDE_W-1:0]           side_out
);
  import rpa_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] res;
    logic [SQ_W-1:0]   rad;
  } sqrt_state_t;

  function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    sqrt_state_t      n;
    shifted = {s.rem[REM_W-3:0], s.rad[SQ_W-1:SQ_W-2]};
    trial = {2'b00, s.res, 2'b01};
    n.rad = {s.rad[SQ_W-3:0], 2'b00};
    if (shifted >= trial) begin
      n.rem = shifted - trial;
      n.res = {s.res[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem = shifted;
      n.res = {s.res[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  sqrt_state_t      init;
  sqrt_state_t      st    [1:ROOT_STAGES];
  logic             vld   [1:ROOT_STAGES];
  logic [SIDE_W-1:0] side [1:ROOT_STAGES];

  assign init = '{rem: '0, res: '0, rad: radicand};

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    sqrt_state_t       cur;
    logic              cur_vld;
    logic [SIDE_W-1:0] cur_side;

    if (s == 0) begin : g_first
      assign cur = init;
      assign cur_vld = in_valid;
      assign cur_side = side_in;
    end else begin : g_rest
      assign cur = st[s];
      assign cur_vld = vld[s];
      assign cur_side = side[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= cur_vld;
      end
      if (en) begin
        st[s+1] <= sqrt_step(sqrt_step(cur));
        side[s+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[ROOT_STAGES];
  assign root = st[ROOT_STAGES].res;
  assign side_out = side[ROOT_STAGES];

endmodule

// ===== rtl/rpa_cordic.sv =====
// ----------------------------------------------------------------------------
// rpa_cordic
// Vectoring CORDIC pipeline: a half-turn pre-rotation stage, then one
// register stage per micro-rotation, accumulating the angle in Q30 radians.
// ----------------------------------------------------------------------------
module rpa_cordic #(
  parameter int ITERATIONS = rpa_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [rpa_pkg::DATA_W-1:0] a_in,
  input  logic signed [rpa_pkg::DATA_W-1:0] b_in,
  output logic                              out_valid,
  output logic signed [rpa_pkg::ANG_W-1:0]  angle
);
  import rpa_pkg::*;

  localparam int N = (ITERATIONS > TABLE_SIZE) ? TABLE_SIZE : ITERATIONS;

  logic signed [DATA_W-1:0] a_q   [0:N];
  logic signed [DATA_W-1:0] b_q   [0:N];
  logic signed [ANG_W-1:0]  acc_q [0:N];
  logic                     vld_q [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
    if (en) begin
      if (b_in < 0) begin
        acc_q[0] <= (a_in >= 0) ? PI_Q30 : -PI_Q30;
        a_q[0] <= -a_in;
        b_q[0] <= -b_in;
      end else begin
        acc_q[0] <= '0;
        a_q[0] <= a_in;
        b_q[0] <= b_in;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [DATA_W-1:0] da;
    logic signed [DATA_W-1:0] db;
    logic signed [ANG_W-1:0]  step;
    logic signed [DATA_W-1:0] a_next;
    logic signed [DATA_W-1:0] b_next;
    logic signed [ANG_W-1:0]  acc_next;

    assign da = b_q[i] >>> i;
    assign db = a_q[i] >>> i;
    assign step = $signed(ANG_W'(ATAN_TABLE[i]));

    always_comb begin
      a_next = a_q[i];
      b_next = b_q[i];
      acc_next = acc_q[i];
      if (a_q[i] > 0) begin
        a_next = a_q[i] - da;
        b_next = b_q[i] + db;
        acc_next = acc_q[i] + step;
      end else if (a_q[i] < 0) begin
        a_next = a_q[i] + da;
        b_next = b_q[i] - db;
        acc_next = acc_q[i] - step;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
      if (en) begin
        a_q[i+1] <= a_next;
        b_q[i+1] <= b_next;
        acc_q[i+1] <= acc_next;
      end
    end
  end

  assign out_valid = vld_q[N];
  assign angle = acc_q[N];

endmodule

// ===== rtl/rpa_scale.sv =====
// ----------------------------------------------------------------------------
// rpa_scale
// Converts a Q30 radian angle to degrees times 128 with round-half-away
// rounding and saturation, over five register stages.
// ----------------------------------------------------------------------------
module rpa_scale #(
  parameter int OUT_W = 16,
  parameter int LIMIT = 23040
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [rpa_pkg::ANG_W-1:0] angle,
  output logic                             out_valid,
  output logic signed [OUT_W-1:0]          degrees
);
  import rpa_pkg::*;

  localparam int MAG_W = ANG_W - 1;
  localparam int PROD_W = MAG_W + 16;
  localparam int U_W = PROD_W + 1 - DEG_SHIFT;
  localparam int W_W = U_W + 20;
  localparam int Q_W = W_W - RECIP5_SHIFT;

  logic [4:0]          vld;
  logic [3:0]          neg;
  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [U_W-1:0]      u;
  logic [W_W-1:0]      w;
  logic [PROD_W:0]     rounded;
  logic [Q_W-1:0]      q;
  logic [OUT_W-2:0]    qs;
  logic signed [OUT_W-1:0] mag_s;

  assign rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(DEG_HALF);
  assign q = w[W_W-1:RECIP5_SHIFT];
  assign qs = (q > Q_W'(LIMIT)) ? (OUT_W - 1)'(LIMIT) : (OUT_W - 1)'(q);
  assign mag_s = $signed({1'b0, qs});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
    if (en) begin
      neg <= {neg[2:0], angle[ANG_W-1]};
      mag <= angle[ANG_W-1] ? MAG_W'(-angle) : MAG_W'(angle);
      prod <= PROD_W'(mag) * PROD_W'(DEG_NUM);
      u <= U_W'(rounded >> DEG_SHIFT);
      w <= W_W'(u) * W_W'(RECIP5);
      degrees <= neg[3] ? -mag_s : mag_s;
    end
  end

  assign out_valid = vld[4];

endmodule

// ===== rtl/roll_pitch_from_accel_core.sv =====
// ----------------------------------------------------------------------------
// roll_pitch_from_accel_core
// Throughput is one sample per cycle while the result side does not stall;
// the whole pipeline advances together. Samples pass through the input
// registers, the 16-stage square root, the CORDIC stages and the scaler.
// The synchronous reset clears all valid bits; no request is lost or repeated
// while the result side stalls, since every stage holds under back-pressure.
// ----------------------------------------------------------------------------
module roll_pitch_from_accel_core #(
  parameter int ANGLE_ITERATIONS = rpa_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rpa_sample_if.sink   sample,
  rpa_result_if.source result
);
  import rpa_pkg::*;

  localparam int SIDE_W = 3 * SAMPLE_W;

  logic en;
  logic vld_a;
  logic vld_b;
  logic vld_c;
  logic signed [SAMPLE_W-1:0] x_a;
  logic signed [SAMPLE_W-1:0] y_a;
  logic signed [SAMPLE_W-1:0] z_a;
  logic signed [SAMPLE_W-1:0] x_b;
  logic signed [SAMPLE_W-1:0] y_b;
  logic signed [SAMPLE_W-1:0] z_b;
  logic [SQ_W-2:0] yy_b;
  logic [SQ_W-2:0] zz_b;
  logic [SIDE_W-1:0] side_c;
  logic [SQ_W-1:0] sq_c;
  logic signed [2*SAMPLE_W-1:0] yy_p;
  logic signed [2*SAMPLE_W-1:0] zz_p;

  logic               root_vld;
  logic [ROOT_W-1:0]  root;
  logic [SIDE_W-1:0]  side_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [SAMPLE_W-1:0] z_r;
  logic signed [DATA_W-1:0] roll_a;
  logic signed [DATA_W-1:0] roll_b;
  logic signed [DATA_W-1:0] pitch_a;
  logic signed [DATA_W-1:0] pitch_b;

  logic                    roll_cvld;
  logic                    pitch_cvld;
  logic signed [ANG_W-1:0] roll_rad;
  logic signed [ANG_W-1:0] pitch_rad;
  logic                    roll_vld;
  logic                    pitch_vld;

  assign en = !result.valid || result.ready;
  assign sample.ready = en;

  assign yy_p = y_a * y_a;
  assign zz_p = z_a * z_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else if (en) begin
      vld_a <= sample.valid;
      vld_b <= vld_a;
      vld_c <= vld_b;
    end
    if (en) begin
      x_a <= sample.accel_x;
      y_a <= sample.accel_y;
      z_a <= sample.accel_z;
      x_b <= x_a;
      y_b <= y_a;
      z_b <= z_a;
      yy_b <= (SQ_W - 1)'(yy_p);
      zz_b <= (SQ_W - 1)'(zz_p);
      sq_c <= SQ_W'(yy_b) + SQ_W'(zz_b);
      side_c <= {x_b, y_b, z_b};
    end
  end

  rpa_isqrt #(
    .SIDE_W(SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld_c),
    .radicand (sq_c),
    .side_in  (side_c),
    .out_valid(root_vld),
    .root     (root),
    .side_out (side_r)
  );

  assign x_r = $signed(side_r[3*SAMPLE_W-1:2*SAMPLE_W]);
  assign y_r = $signed(side_r[2*SAMPLE_W-1:SAMPLE_W]);
  assign z_r = $signed(side_r[SAMPLE_W-1:0]);

  assign roll_a = DATA_W'(y_r) <<< FRAC_W;
  assign roll_b = DATA_W'(z_r) <<< FRAC_W;
  assign pitch_a = -(DATA_W'(x_r) <<< FRAC_W);
  assign pitch_b = $signed(DATA_W'({root, ROOT_SHIFT'(0)}));

  rpa_cordic #(
    .ITERATIONS(ANGLE_ITERATIONS)
  ) u_cordic_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (root_vld),
    .a_in     (roll_a),
    .b_in     (roll_b),
    .out_valid(roll_cvld),
    .angle    (roll_rad)
  );

  rpa_cordic #(
    .ITERATIONS(ANGLE_ITERATIONS)
  ) u_cordic_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (root_vld),
    .a_in     (pitch_a),
    .b_in     (pitch_b),
    .out_valid(pitch_cvld),
    .angle    (pitch_rad)
  );

  rpa_scale #(
    .OUT_W(ROLL_W),
    .LIMIT(ROLL_LIMIT)
  ) u_scale_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (roll_cvld),
    .angle    (roll_rad),
    .out_valid(roll_vld),
    .degrees  (result.roll_angle)
  );

  rpa_scale #(
    .OUT_W(PITCH_W),
    .LIMIT(PITCH_LIMIT)
  ) u_scale_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pitch_cvld),
    .angle    (pitch_rad),
    .out_valid(pitch_vld),
    .degrees  (result.pitch_angle)
  );

  assign result.valid = roll_vld && pitch_vld;

endmodule
